>>> sv/dvfs_pkg.sv
// Shared types and constants of the DVFS operating-point sequencer.
// Used by the table, configuration and sequencer modules; depends on nothing.
package dvfs_pkg;

	// One operating point as it is stored in the table memory (60 bits).
	typedef struct packed {
		logic [20:0] freq;
		logic [2:0]  src;
		logic [2:0]  sel;
		logic [3:0]  div;
		logic [17:0] bus;
		logic [10:0] mv;
	} op_entry_t;

	// Configuration register values as seen by the sequencer.
	typedef struct packed {
		logic        pll2_half_step;
		logic [10:0] vdd_min_mv;
		logic [10:0] vdd_max_mv;
	} cfg_t;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_RATE   = 2'd1;
	localparam logic [1:0] KIND_ADJUST = 2'd2;
	localparam logic [1:0] KIND_CHECK  = 2'd3;

	localparam logic [1:0] REASON_SCALE = 2'd0;
	localparam logic [1:0] REASON_WFI   = 2'd1;
	localparam logic [1:0] REASON_PC    = 2'd2;

	localparam logic [2:0] CMD_STATUS  = 3'd0;
	localparam logic [2:0] CMD_SET_V   = 3'd1;
	localparam logic [2:0] CMD_SET_BUS = 3'd2;
	localparam logic [2:0] CMD_PLL_ON  = 3'd3;
	localparam logic [2:0] CMD_PLL_OFF = 3'd4;
	localparam logic [2:0] CMD_CTL     = 3'd5;
	localparam logic [2:0] CMD_PLL2_L  = 3'd6;
	localparam logic [2:0] CMD_SELECT  = 3'd7;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREQ = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic [2:0] SRC_PLL1 = 3'd2;
	localparam logic [2:0] SRC_PLL2 = 3'd3;
	localparam logic [2:0] SRC_PLL3 = 3'd4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PLL2_HALF = 2'd0;
	localparam logic [1:0] REG_VDD_MIN   = 2'd1;
	localparam logic [1:0] REG_VDD_MAX   = 2'd2;

	localparam logic [10:0] VDD_MIN_RESET = 11'd800;
	localparam logic [10:0] VDD_MAX_RESET = 11'd1600;

	// Positions in the ordered command run; the last one is the status.
	localparam logic [3:0] STEP_V_UP    = 4'd0;
	localparam logic [3:0] STEP_BUS_UP  = 4'd1;
	localparam logic [3:0] STEP_PLL_ON  = 4'd2;
	localparam logic [3:0] STEP_CTL     = 4'd3;
	localparam logic [3:0] STEP_L       = 4'd4;
	localparam logic [3:0] STEP_SEL     = 4'd5;
	localparam logic [3:0] STEP_PLL_OFF = 4'd6;
	localparam logic [3:0] STEP_BUS_DN  = 4'd7;
	localparam logic [3:0] STEP_V_DN    = 4'd8;
	localparam logic [3:0] STEP_STATUS  = 4'd9;
	localparam int         NUM_STEPS    = 10;

	// Reciprocals: x*2622>>16 equals x/25 for x <= 2048,
	// x*27963>>21 equals x/75 for x < 16384.
	localparam logic [11:0] RECIP_25      = 12'd2622;
	localparam logic [14:0] RECIP_75      = 15'd27963;
	localparam logic [6:0]  VCODE_OFFSET  = 7'd30;
	localparam logic [2:0]  VCODE_TOP     = 3'b111;
	localparam logic [20:0] L_HIGH_KHZ    = 21'd1500000;

	// Voltage code: ((mv/25 - 30) mod 256) | 0xE0.
	function automatic logic [7:0] vcode(input logic [10:0] mv);
		logic [22:0] prod;
		logic [6:0]  q;
		logic [6:0]  d;
		prod = mv * RECIP_25;
		q    = prod[22:16];
		d    = q - VCODE_OFFSET;
		return {VCODE_TOP, d[4:0]};
	endfunction

	function automatic logic is_pll(input logic [2:0] src);
		return (src == SRC_PLL1) || (src == SRC_PLL2) || (src == SRC_PLL3);
	endfunction

endpackage

>>> sv/dvfs_table.sv
// Operating-point table: a single-port-write, single-port-read synchronous
// memory with a registered read and per-slot valid bits. Uses dvfs_pkg.
module dvfs_table #(
	parameter int TABLE_ENTRIES = 32,
	parameter int SW            = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [SW-1:0]       wr_addr,
	input  dvfs_pkg::op_entry_t wr_data,
	input  logic [SW-1:0]       rd_addr,
	output dvfs_pkg::op_entry_t rd_data
);
	import dvfs_pkg::*;

	op_entry_t                mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	op_entry_t                rd_q;
	logic                     rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	// A slot never written reads as the all-zero reset entry.
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

>>> sv/dvfs_cfg.sv
// APB-style configuration registers of the DVFS sequencer.
// Uses dvfs_pkg for register indexes and reset values.
module dvfs_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output dvfs_pkg::cfg_t cfg
);
	import dvfs_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pll2_half_step <= 1'b0;
			cfg_q.vdd_min_mv     <= VDD_MIN_RESET;
			cfg_q.vdd_max_mv     <= VDD_MAX_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_PLL2_HALF: cfg_q.pll2_half_step <= pwdata[0];
				REG_VDD_MIN:   cfg_q.vdd_min_mv     <= pwdata[10:0];
				REG_VDD_MAX:   cfg_q.vdd_max_mv     <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_PLL2_HALF: prdata = {31'b0, cfg_q.pll2_half_step};
			REG_VDD_MIN:   prdata = {21'b0, cfg_q.vdd_min_mv};
			REG_VDD_MAX:   prdata = {21'b0, cfg_q.vdd_max_mv};
			default:       prdata = '0;
		endcase
	end

endmodule

>>> sv/dvfs_seq.sv
// Request sequencer: reads, modifies and writes back the operating-point
// table and issues the ordered command run. Uses dvfs_pkg.
module dvfs_seq #(
	parameter int TABLE_ENTRIES = 32,
	parameter int SW            = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dvfs_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [4:0]          index,
	input  logic [20:0]         freq_khz,
	input  logic [2:0]          source,
	input  logic [2:0]          mux_select,
	input  logic [3:0]          divider,
	input  logic [17:0]         bus_khz,
	input  logic signed [11:0]  voltage,
	input  logic [1:0]          reason,
	input  logic                make_current,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          command,
	output logic [20:0]         value,
	output logic [1:0]          status,
	output logic                last,
	output logic                wr_en,
	output logic [SW-1:0]       wr_addr,
	output dvfs_pkg::op_entry_t wr_data,
	output logic [SW-1:0]       rd_addr,
	input  dvfs_pkg::op_entry_t rd_data
);
	import dvfs_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_ADJ_PREP = 9'b000000010,
		S_RD_OLD   = 9'b000000100,
		S_OLD_EV   = 9'b000001000,
		S_SCAN_RD  = 9'b000010000,
		S_SCAN_EV  = 9'b000100000,
		S_RD_CUR   = 9'b001000000,
		S_CUR_EV   = 9'b010000000,
		S_EMIT     = 9'b100000000
	} state_t;

	localparam logic [SW-1:0]        LAST_SLOT   = SW'(TABLE_ENTRIES - 1);
	localparam logic [NUM_STEPS-1:0] EN_STATUS   = NUM_STEPS'(1) << STEP_STATUS;

	state_t               state_q;
	logic [1:0]           kind_q;
	logic [20:0]          freq_q;
	logic [1:0]           reason_q;
	logic signed [11:0]   vol_q;
	logic signed [13:0]   step_mv_q;
	op_entry_t            o_q;
	op_entry_t            n_q;
	logic [SW-1:0]        i_q;
	logic [SW-1:0]        cur_q;
	logic [15:0]          image_q;
	logic                 sel_q;
	logic [NUM_STEPS-1:0] en_q;
	logic [3:0]           step_q;
	logic [1:0]           status_q;
	logic                 out_valid_q;
	logic [2:0]           command_q;
	logic [20:0]          value_q;
	logic [1:0]           status_out_q;
	logic                 last_q;

	logic                 accept;
	logic                 load_ok;
	logic                 out_free;
	logic                 emit_go;
	logic                 tbl_end;
	logic                 tbl_hit;
	logic                 scan_done;
	logic                 vol_bad;
	logic [10:0]          adj_mv;
	logic [11:0]          vol_abs;
	logic [23:0]          step_prod;
	logic [6:0]           step_q25;
	logic [10:0]          step_mag;
	logic [15:0]          new_image;
	logic [13:0]          l_x;
	logic [28:0]          l_prod;
	logic [20:0]          l_val;
	logic [2:0]           emit_cmd;
	logic [20:0]          emit_val;
	logic [NUM_STEPS-1:0] rate_en;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign load_ok   = (32'(index) < TABLE_ENTRIES);
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_go   = (state_q == S_EMIT) && en_q[step_q] && out_free;
	assign out_valid = out_valid_q;
	assign command   = command_q;
	assign value     = value_q;
	assign status    = status_out_q;
	assign last      = last_q;

	assign rd_addr   = (state_q == S_RD_OLD || state_q == S_RD_CUR) ? cur_q : i_q;
	assign tbl_end   = (rd_data.freq == 21'd0);
	assign tbl_hit   = !tbl_end && (rd_data.freq == freq_q);
	assign scan_done = tbl_end || (i_q == LAST_SLOT);
	assign vol_bad   = ($signed({vol_q[11], vol_q}) > $signed({2'b00, cfg.vdd_max_mv})) ||
	                   ($signed({vol_q[11], vol_q}) < $signed({2'b00, cfg.vdd_min_mv}));

	// Offset rounded toward zero to a multiple of 25 mV.
	assign vol_abs   = vol_q[11] ? 12'(-vol_q) : 12'(vol_q);
	assign step_prod = vol_abs * RECIP_25;
	assign step_q25  = step_prod[22:16];
	assign step_mag  = ({4'b0, step_q25} << 4) + ({4'b0, step_q25} << 3) + {4'b0, step_q25};

	function automatic logic [10:0] clamp(input logic signed [13:0] v,
	                                      input logic [10:0] lo,
	                                      input logic [10:0] hi);
		logic signed [13:0] r;
		r = v;
		if (r < $signed({3'b000, lo})) begin
			r = $signed({3'b000, lo});
		end
		if (r > $signed({3'b000, hi})) begin
			r = $signed({3'b000, hi});
		end
		return r[10:0];
	endfunction

	always_comb begin
		if (freq_q == 21'd0) begin
			adj_mv = clamp($signed({3'b000, rd_data.mv}) + step_mv_q,
			               cfg.vdd_min_mv, cfg.vdd_max_mv);
		end else begin
			adj_mv = clamp(step_mv_q, cfg.vdd_min_mv, cfg.vdd_max_mv);
		end
	end

	// Conditions of the command run for a matched rate request.
	always_comb begin
		rate_en = '0;
		rate_en[STEP_V_UP]    = (reason_q == REASON_SCALE) && (rd_data.mv > o_q.mv);
		rate_en[STEP_BUS_UP]  = rd_data.bus > o_q.bus;
		rate_en[STEP_PLL_ON]  = (o_q.src != rd_data.src) && is_pll(rd_data.src);
		rate_en[STEP_CTL]     = 1'b1;
		rate_en[STEP_L]       = (rd_data.src == SRC_PLL2);
		rate_en[STEP_SEL]     = 1'b1;
		rate_en[STEP_PLL_OFF] = (reason_q != REASON_WFI) && (o_q.src != rd_data.src) &&
		                        is_pll(o_q.src);
		rate_en[STEP_BUS_DN]  = (reason_q != REASON_WFI) && (rd_data.bus < o_q.bus);
		rate_en[STEP_V_DN]    = (reason_q != REASON_WFI) && (reason_q != REASON_PC) &&
		                        (rd_data.mv < o_q.mv);
		rate_en[STEP_STATUS]  = 1'b1;
	end

	// Table write port: loads, voltage adjustments and checked updates.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = rd_data;
		if (accept && kind == KIND_LOAD && load_ok) begin
			wr_en        = 1'b1;
			wr_addr      = SW'(index);
			wr_data.freq = freq_khz;
			wr_data.src  = source;
			wr_data.sel  = mux_select;
			wr_data.div  = divider;
			wr_data.bus  = bus_khz;
			wr_data.mv   = voltage[11] ? 11'd0 : voltage[10:0];
		end else if (state_q == S_SCAN_EV && !tbl_end) begin
			if (kind_q == KIND_ADJUST && (freq_q == 21'd0 || tbl_hit)) begin
				wr_en      = 1'b1;
				wr_data.mv = adj_mv;
			end else if (kind_q == KIND_CHECK && tbl_hit && !vol_bad) begin
				wr_en      = 1'b1;
				wr_data.mv = vol_q[10:0];
			end
		end
	end

	// Clock-control image: the byte picked by the select bit gets mux and divider.
	always_comb begin
		if (sel_q) begin
			new_image = {1'b0, n_q.sel, n_q.div, image_q[7:0]};
		end else begin
			new_image = {image_q[15:8], 1'b0, n_q.sel, n_q.div};
		end
	end

	// PLL2 L value: freq/19200 or freq/9600, one less above 1.5 GHz.
	assign l_x    = cfg.pll2_half_step ? n_q.freq[20:7] : {1'b0, n_q.freq[20:8]};
	assign l_prod = l_x * RECIP_75;
	assign l_val  = (n_q.freq > L_HIGH_KHZ) ? 21'(l_prod[28:21]) - 21'd1 :
	                21'(l_prod[28:21]);

	always_comb begin
		unique case (step_q)
			STEP_V_UP:    begin emit_cmd = CMD_SET_V;   emit_val = 21'(vcode(n_q.mv)); end
			STEP_BUS_UP:  begin emit_cmd = CMD_SET_BUS; emit_val = 21'(n_q.bus); end
			STEP_PLL_ON:  begin emit_cmd = CMD_PLL_ON;  emit_val = 21'(n_q.src - 3'd1); end
			STEP_CTL:     begin emit_cmd = CMD_CTL;     emit_val = 21'(new_image); end
			STEP_L:       begin emit_cmd = CMD_PLL2_L;  emit_val = l_val; end
			STEP_SEL:     begin emit_cmd = CMD_SELECT;  emit_val = 21'(!sel_q); end
			STEP_PLL_OFF: begin emit_cmd = CMD_PLL_OFF; emit_val = 21'(o_q.src - 3'd1); end
			STEP_BUS_DN:  begin emit_cmd = CMD_SET_BUS; emit_val = 21'(n_q.bus); end
			STEP_V_DN:    begin emit_cmd = CMD_SET_V;   emit_val = 21'(vcode(n_q.mv)); end
			default:      begin emit_cmd = CMD_STATUS;  emit_val = 21'd0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= KIND_LOAD;
			freq_q       <= '0;
			reason_q     <= '0;
			vol_q        <= '0;
			step_mv_q    <= '0;
			o_q          <= '0;
			n_q          <= '0;
			i_q          <= '0;
			cur_q        <= '0;
			image_q      <= '0;
			sel_q        <= 1'b0;
			en_q         <= '0;
			step_q       <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			command_q    <= CMD_STATUS;
			value_q      <= '0;
			status_out_q <= ST_OK;
			last_q       <= 1'b0;
		end else begin
			out_valid_q <= emit_go || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q   <= kind;
						freq_q   <= freq_khz;
						reason_q <= reason;
						vol_q    <= voltage;
						i_q      <= '0;
						step_q   <= STEP_V_UP;
						en_q     <= EN_STATUS;
						status_q <= ST_OK;
						unique case (kind)
							KIND_LOAD: begin
								if (load_ok && make_current) begin
									cur_q <= SW'(index);
								end
								state_q <= S_EMIT;
							end
							KIND_RATE:   state_q <= S_RD_OLD;
							KIND_ADJUST: state_q <= S_ADJ_PREP;
							default:     state_q <= S_SCAN_RD;
						endcase
					end
				end
				S_ADJ_PREP: begin
					step_mv_q <= vol_q[11] ? -$signed({3'b000, step_mag}) :
					             $signed({3'b000, step_mag});
					state_q   <= S_SCAN_RD;
				end
				S_RD_OLD: state_q <= S_OLD_EV;
				S_OLD_EV: begin
					o_q <= rd_data;
					if (rd_data.freq == freq_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_EV;
				S_SCAN_EV: begin
					if (kind_q == KIND_RATE && tbl_hit) begin
						n_q     <= rd_data;
						en_q    <= rate_en;
						state_q <= S_EMIT;
					end else if (kind_q == KIND_CHECK && tbl_hit) begin
						if (vol_bad) begin
							status_q <= ST_RANGE;
							state_q  <= S_EMIT;
						end else begin
							n_q.mv  <= vol_q[10:0];
							state_q <= S_RD_CUR;
						end
					end else if (scan_done) begin
						if (kind_q != KIND_ADJUST) begin
							status_q <= ST_NO_FREQ;
						end
						state_q <= S_EMIT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_RD_CUR: state_q <= S_CUR_EV;
				S_CUR_EV: begin
					if (rd_data.freq == freq_q) begin
						en_q[STEP_V_DN] <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!en_q[step_q]) begin
						step_q <= step_q + 4'd1;
					end else if (out_free) begin
						command_q    <= emit_cmd;
						value_q      <= emit_val;
						status_out_q <= (step_q == STEP_STATUS) ? status_q : ST_OK;
						last_q       <= (step_q == STEP_STATUS);
						if (step_q == STEP_CTL) begin
							image_q <= new_image;
						end
						if (step_q == STEP_SEL) begin
							sel_q <= !sel_q;
							cur_q <= i_q;
						end
						if (step_q == STEP_STATUS) begin
							state_q <= S_IDLE;
						end
						step_q <= step_q + 4'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sv/dvfs_operating_point_sequencer.sv
// Top level of the DVFS operating-point sequencer: ties the configuration
// registers, the operating-point table memory and the request sequencer.
// Depends on dvfs_pkg, dvfs_cfg, dvfs_table and dvfs_seq.
//
// The block keeps a table of CPU operating points (frequency, clock source,
// mux select, divider, bus rate, core voltage) in a synchronous memory with
// a registered read, and it works on one request at a time. A request
// loads an entry, asks for a new rate, shifts voltages, or sets the voltage
// of one entry under range check. Every request ends with a status result
// that carries last; a matched rate change first issues its ordered run of
// commands (voltage up, bus up, PLL on, clock-control write, PLL2 L value,
// select toggle, PLL off, bus down, voltage down) as its conditions call for.
// Every table lookup walks the slots in order through the single read port,
// with a read and an evaluate state per slot, and stops at the first empty
// slot, at the last slot or, for a rate or checked request, at the match.
// A rate request first reads the running entry; a checked update reads it
// after the match and issues a voltage command if it is the entry updated;
// a voltage adjust first forms its rounded step. The command run then steps
// through its positions in order, skips those not called for and waits
// while the output is stalled. The next request can be taken once the status
// result is in the output register. Table slots come out of reset empty
// through per-slot valid bits; no clearing pass is needed. Configuration is
// written through the APB-style port at byte addresses 0, 4 and 8. The user
// must do so only while no request is in progress; the block does not check.
module dvfs_operating_point_sequencer #(
	parameter int TABLE_ENTRIES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [4:0]         index,
	input  logic [20:0]        freq_khz,
	input  logic [2:0]         source,
	input  logic [2:0]         mux_select,
	input  logic [3:0]         divider,
	input  logic [17:0]        bus_khz,
	input  logic signed [11:0] voltage,
	input  logic [1:0]         reason,
	input  logic               make_current,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         command,
	output logic [20:0]        value,
	output logic [1:0]         status,
	output logic               last
);
	import dvfs_pkg::*;

	// Slot index width of the table.
	localparam int SW = $clog2(TABLE_ENTRIES);

	cfg_t          cfg;
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	op_entry_t     wr_data;
	logic [SW-1:0] rd_addr;
	op_entry_t     rd_data;

	dvfs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dvfs_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.SW            (SW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dvfs_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.SW            (SW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.index        (index),
		.freq_khz     (freq_khz),
		.source       (source),
		.mux_select   (mux_select),
		.divider      (divider),
		.bus_khz      (bus_khz),
		.voltage      (voltage),
		.reason       (reason),
		.make_current (make_current),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command      (command),
		.value        (value),
		.status       (status),
		.last         (last),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data)
	);

endmodule
